// ===== design/fsr_pkg.sv =====
// fsr_pkg: shared constants, widths and item types for the frame section reassembler
// no dependencies
package fsr_pkg;

  localparam int SLOT_COUNT    = 4;
  localparam int SECTION_BYTES = 1024;
  localparam int SECTIONS_MAX  = 64;

  localparam int SLOT_SIZE = SECTIONS_MAX * SECTION_BYTES;
  localparam int MEM_DEPTH = SLOT_COUNT * SLOT_SIZE;

  localparam int FRAME_W     = 16;
  localparam int SEC_W       = 6;
  localparam int CNT_W       = 7;
  localparam int POS_W       = 10;
  localparam int DATA_W      = 8;
  localparam int BYTES_W     = 17;
  localparam int DONE_SLOT_W = 2;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int OFF_W  = SEC_W + $clog2(SECTION_BYTES) + 1;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_IDX_W = 2;
  localparam int RQ_DEPTH = 2;
  localparam int RQ_IDX_W = 1;

  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [FRAME_W-1:0] frame;
    logic [CNT_W-1:0]   count;
    logic [ADDR_W-1:0]  addr;
    logic               store;
    logic [DATA_W-1:0]  data;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic [DONE_SLOT_W-1:0] done_slot;
    logic [FRAME_W-1:0]     done_frame;
    logic [BYTES_W-1:0]     frame_bytes;
  } res_t;

  typedef struct packed {
    logic   valid;
    cmd_t   cmd;
  } cmd_chan_t;

endpackage

// ===== design/fsr_front.sv =====
// fsr_front: accepts input items, works out slot and store address, queues them
// depends on fsr_pkg
module fsr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic [fsr_pkg::FRAME_W-1:0]   in_frame_number,
  input  logic [fsr_pkg::SEC_W-1:0]     in_section_index,
  input  logic [fsr_pkg::CNT_W-1:0]     in_section_count,
  input  logic [fsr_pkg::POS_W-1:0]     in_byte_in_section,
  input  logic [fsr_pkg::DATA_W-1:0]    in_data_byte,
  input  logic                          in_last_in_section,
  output logic                          in_full,
  output fsr_pkg::cmd_chan_t            cmd_chan,
  input  logic                          cmd_ready
);

  fsr_pkg::cmd_t                   q_r [fsr_pkg::CQ_DEPTH];
  logic [fsr_pkg::CQ_IDX_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [fsr_pkg::CQ_IDX_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [fsr_pkg::CQ_IDX_W:0]      cnt_r, cnt_nxt;
  logic [fsr_pkg::SLOT_W-1:0]      slot;
  logic [fsr_pkg::OFF_W-1:0]       offset;
  fsr_pkg::cmd_t                   cmd_new;
  logic                            push;
  logic                            pop;

  // slot, offset in slot and flat store address
  always_comb begin
    slot   = fsr_pkg::SLOT_W'(in_frame_number % fsr_pkg::SLOT_COUNT);
    offset = fsr_pkg::OFF_W'(in_section_index) * fsr_pkg::OFF_W'(fsr_pkg::SECTION_BYTES)
           + fsr_pkg::OFF_W'(in_byte_in_section);
    cmd_new.slot  = slot;
    cmd_new.frame = in_frame_number;
    cmd_new.count = in_section_count;
    cmd_new.addr  = fsr_pkg::ADDR_W'(slot) * fsr_pkg::ADDR_W'(fsr_pkg::SLOT_SIZE)
                  + fsr_pkg::ADDR_W'(offset);
    cmd_new.store = 32'(offset) < 32'(fsr_pkg::SLOT_SIZE);
    cmd_new.data  = in_data_byte;
    cmd_new.last  = in_last_in_section;
  end

  assign in_full        = cnt_r == (fsr_pkg::CQ_IDX_W+1)'(fsr_pkg::CQ_DEPTH);
  assign cmd_chan.valid = cnt_r != '0;
  assign cmd_chan.cmd   = q_r[rd_ptr_r];
  assign push           = in_push & ~in_full;
  assign pop            = cmd_chan.valid & cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? fsr_pkg::CQ_IDX_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? fsr_pkg::CQ_IDX_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_new;
    end
  end

endmodule

// ===== design/fsr_back.sv =====
// fsr_back: slot table update, frame store write and completion detection
// depends on fsr_pkg
module fsr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fsr_pkg::cmd_chan_t  cmd_chan,
  output logic                cmd_ready,
  output logic                res_push,
  output fsr_pkg::res_t       res,
  input  logic                res_full
);

  logic [fsr_pkg::DATA_W-1:0]  mem_r   [fsr_pkg::MEM_DEPTH];
  logic [fsr_pkg::FRAME_W-1:0] tag_r   [fsr_pkg::SLOT_COUNT];
  logic                        valid_r [fsr_pkg::SLOT_COUNT];
  logic [fsr_pkg::CNT_W-1:0]   rem_r   [fsr_pkg::SLOT_COUNT];
  logic [fsr_pkg::BYTES_W-1:0] bytes_r [fsr_pkg::SLOT_COUNT];

  fsr_pkg::cmd_t               c;
  logic                        fire;
  logic                        hit;
  logic [fsr_pkg::CNT_W-1:0]   rem_cur, rem_nxt;
  logic [fsr_pkg::BYTES_W-1:0] bytes_cur, bytes_nxt;
  logic                        done;

  assign c         = cmd_chan.cmd;
  assign cmd_ready = ~res_full;
  assign fire      = cmd_chan.valid & cmd_ready;

  // reclaim on miss, count the byte, close a section on its flagged byte
  always_comb begin
    hit       = valid_r[c.slot] && (tag_r[c.slot] == c.frame);
    rem_cur   = hit ? rem_r[c.slot] : c.count;
    bytes_cur = hit ? bytes_r[c.slot] : '0;
    bytes_nxt = (bytes_cur == fsr_pkg::BYTES_MAX) ? bytes_cur : bytes_cur + 1'b1;
    rem_nxt   = rem_cur;
    done      = 1'b0;
    if (c.last && rem_cur != '0) begin
      rem_nxt = rem_cur - 1'b1;
      done    = rem_nxt == '0;
    end
  end

  assign res_push        = fire & done;
  assign res.done_slot   = fsr_pkg::DONE_SLOT_W'(c.slot);
  assign res.done_frame  = c.frame;
  assign res.frame_bytes = bytes_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fsr_pkg::SLOT_COUNT; i++) begin
        valid_r[i] <= 1'b0;
        tag_r[i]   <= '0;
        rem_r[i]   <= '0;
        bytes_r[i] <= '0;
      end
    end else if (fire) begin
      valid_r[c.slot] <= 1'b1;
      tag_r[c.slot]   <= c.frame;
      rem_r[c.slot]   <= rem_nxt;
      bytes_r[c.slot] <= bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && c.store) begin
      mem_r[c.addr] <= c.data;
    end
  end

endmodule

// ===== design/fsr_outq.sv =====
// fsr_outq: two-entry result queue between the back part and the result ports
// depends on fsr_pkg
module fsr_outq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              res_push,
  input  fsr_pkg::res_t                     res,
  output logic                              res_full,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [fsr_pkg::DONE_SLOT_W-1:0]   out_done_slot,
  output logic [fsr_pkg::FRAME_W-1:0]       out_done_frame,
  output logic [fsr_pkg::BYTES_W-1:0]       out_frame_bytes
);

  fsr_pkg::res_t                 q_r [fsr_pkg::RQ_DEPTH];
  logic [fsr_pkg::RQ_IDX_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [fsr_pkg::RQ_IDX_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [fsr_pkg::RQ_IDX_W:0]    cnt_r, cnt_nxt;
  logic                          push;
  logic                          pop;
  fsr_pkg::res_t                 head;

  assign res_full  = cnt_r == (fsr_pkg::RQ_IDX_W+1)'(fsr_pkg::RQ_DEPTH);
  assign out_empty = cnt_r == '0;
  assign push      = res_push & ~res_full;
  assign pop       = out_pop & ~out_empty;

  assign head            = q_r[rd_ptr_r];
  assign out_done_slot   = head.done_slot;
  assign out_done_frame  = head.done_frame;
  assign out_frame_bytes = head.frame_bytes;

  always_comb begin
    wr_ptr_nxt = push ? fsr_pkg::RQ_IDX_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? fsr_pkg::RQ_IDX_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= res;
    end
  end

endmodule

// ===== design/frame_section_reassembler_top.sv =====
// frame_section_reassembler_top: byte-serial frame section reassembly into a ring of slots
// instantiates fsr_front, fsr_back and fsr_outq; depends on fsr_pkg
//
// One byte item is accepted per clock while the input queue is not full. The
// front part computes the slot and store address and holds up to four items;
// the back part updates the slot table and writes the frame store, taking one
// item per clock while the result queue has room. With both queues empty a
// completion result shows on the result ports once its item has left the input
// queue and been written into a two-entry result queue; while that queue is
// full the back part holds and the input queue fills.
// No start-up pass is needed: the slot table clears at reset and the frame
// store is write-only.
module frame_section_reassembler_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  logic [fsr_pkg::FRAME_W-1:0]       in_frame_number,
  input  logic [fsr_pkg::SEC_W-1:0]         in_section_index,
  input  logic [fsr_pkg::CNT_W-1:0]         in_section_count,
  input  logic [fsr_pkg::POS_W-1:0]         in_byte_in_section,
  input  logic [fsr_pkg::DATA_W-1:0]        in_data_byte,
  input  logic                              in_last_in_section,
  output logic                              in_full,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [fsr_pkg::DONE_SLOT_W-1:0]   out_done_slot,
  output logic [fsr_pkg::FRAME_W-1:0]       out_done_frame,
  output logic [fsr_pkg::BYTES_W-1:0]       out_frame_bytes
);

  fsr_pkg::cmd_chan_t  cmd_chan;
  logic                cmd_ready;
  logic                res_push;
  fsr_pkg::res_t       res;
  logic                res_full;

  fsr_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_frame_number    (in_frame_number),
    .in_section_index   (in_section_index),
    .in_section_count   (in_section_count),
    .in_byte_in_section (in_byte_in_section),
    .in_data_byte       (in_data_byte),
    .in_last_in_section (in_last_in_section),
    .in_full            (in_full),
    .cmd_chan           (cmd_chan),
    .cmd_ready          (cmd_ready)
  );

  fsr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_chan  (cmd_chan),
    .cmd_ready (cmd_ready),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  fsr_outq u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_push        (res_push),
    .res             (res),
    .res_full        (res_full),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_done_slot   (out_done_slot),
    .out_done_frame  (out_done_frame),
    .out_frame_bytes (out_frame_bytes)
  );

`ifndef NO_ASSERTIONS
  a_no_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(res_push))
    else $error("result appeared without a completion");

  a_stall_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_chan.valid && !cmd_ready) |=> cmd_chan.valid)
    else $error("queued item lost while back part stalled");
`endif

endmodule

// ===== dv/tb.sv =====
// tb: self-checking testbench for frame_section_reassembler_top
// directed table, then random section bursts with a long receiver hold
// depends on fsr_pkg and the design sources
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_DONE} chk_t;

  typedef struct packed {
    logic [fsr_pkg::FRAME_W-1:0] frame;
    logic [fsr_pkg::SEC_W-1:0]   sec;
    logic [fsr_pkg::CNT_W-1:0]   cnt;
    logic [fsr_pkg::POS_W-1:0]   pos;
    logic [fsr_pkg::DATA_W-1:0]  data;
    logic                        last;
  } byte_item_t;

  typedef struct packed {
    byte_item_t    it;
    chk_t          chk;
    fsr_pkg::res_t res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic out_empty;
  logic out_pop;
  logic [fsr_pkg::DONE_SLOT_W-1:0] out_done_slot;
  logic [fsr_pkg::FRAME_W-1:0]     out_done_frame;
  logic [fsr_pkg::BYTES_W-1:0]     out_frame_bytes;

  byte_item_t    cur_item;
  chk_t          cur_chk;
  fsr_pkg::res_t cur_res;

  logic [fsr_pkg::FRAME_W-1:0] slot_owner    [fsr_pkg::SLOT_COUNT];
  logic                        slot_live     [fsr_pkg::SLOT_COUNT];
  logic [fsr_pkg::CNT_W-1:0]   sections_left [fsr_pkg::SLOT_COUNT];
  logic [fsr_pkg::BYTES_W-1:0] byte_total    [fsr_pkg::SLOT_COUNT];

  fsr_pkg::res_t pending_done[$];
  stim_row_t     dir_tab[$];

  int n_accepted;
  int fails;
  int stall_cnt;
  int send_idle;
  int recv_idle;
  int hold_left;
  bit hold_req;
  logic [fsr_pkg::FRAME_W-1:0] prev_base;

  frame_section_reassembler_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_frame_number   (cur_item.frame),
    .in_section_index  (cur_item.sec),
    .in_section_count  (cur_item.cnt),
    .in_byte_in_section(cur_item.pos),
    .in_data_byte      (cur_item.data),
    .in_last_in_section(cur_item.last),
    .in_full           (in_full),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_done_slot     (out_done_slot),
    .out_done_frame    (out_done_frame),
    .out_frame_bytes   (out_frame_bytes)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit predict_completion(input byte_item_t b, output fsr_pkg::res_t r);
    int s;
    bit hit;
    s   = b.frame % fsr_pkg::SLOT_COUNT;
    hit = 1'b0;
    r   = '0;
    if (!slot_live[s] || slot_owner[s] != b.frame) begin
      slot_owner[s]    = b.frame;
      slot_live[s]     = 1'b1;
      sections_left[s] = b.cnt;
      byte_total[s]    = '0;
    end
    if (byte_total[s] < fsr_pkg::BYTES_MAX)
      byte_total[s] = byte_total[s] + 1'b1;
    if (b.last && sections_left[s] != 0) begin
      sections_left[s] = sections_left[s] - 1'b1;
      if (sections_left[s] == 0) begin
        r.done_slot   = s[fsr_pkg::DONE_SLOT_W-1:0];
        r.done_frame  = b.frame;
        r.frame_bytes = byte_total[s];
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic stim_row_t stim_row(input logic [fsr_pkg::FRAME_W-1:0] f,
                                         input logic [fsr_pkg::SEC_W-1:0] s,
                                         input logic [fsr_pkg::CNT_W-1:0] c,
                                         input logic [fsr_pkg::POS_W-1:0] p,
                                         input logic [fsr_pkg::DATA_W-1:0] d,
                                         input logic l,
                                         input chk_t k,
                                         input logic [fsr_pkg::DONE_SLOT_W-1:0] rs,
                                         input logic [fsr_pkg::FRAME_W-1:0] rf,
                                         input logic [fsr_pkg::BYTES_W-1:0] rb);
    stim_row_t row;
    row.it  = '{frame: f, sec: s, cnt: c, pos: p, data: d, last: l};
    row.chk = k;
    row.res = '{done_slot: rs, done_frame: rf, frame_bytes: rb};
    return row;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_byte(input byte_item_t it, input chk_t k, input fsr_pkg::res_t r);
    int target;
    target = n_accepted + 1;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    cur_item <= it;
    cur_chk  <= k;
    cur_res  <= r;
    in_push  <= 1'b1;
    @(negedge clk);
    while (n_accepted < target) @(negedge clk);
  endtask

  task automatic send_batch();
    byte_item_t batch[$];
    byte_item_t b;
    byte_item_t t;
    logic [fsr_pkg::FRAME_W-1:0] base;
    logic [fsr_pkg::POS_W-1:0] start;
    int nf, nsec, nbytes, f, s, k, j;
    base = ($urandom_range(9) == 0) ? prev_base
                                    : fsr_pkg::FRAME_W'($urandom_range(16'hFFFF));
    prev_base = base;
    nf = $urandom_range(1, 3);
    for (f = 0; f < nf; f++) begin
      b.frame = ($urandom_range(99) < 85) ? base + fsr_pkg::FRAME_W'(f)
                                          : fsr_pkg::FRAME_W'($urandom_range(16'hFFFF));
      b.cnt   = ($urandom_range(99) < 6) ? fsr_pkg::CNT_W'($urandom_range(127))
                                         : fsr_pkg::CNT_W'($urandom_range(1, 4));
      nsec    = (b.cnt > 4 || b.cnt == 0) ? $urandom_range(1, 4) : b.cnt;
      for (s = 0; s < nsec; s++) begin
        b.sec  = fsr_pkg::SEC_W'($urandom_range(63));
        start  = fsr_pkg::POS_W'($urandom_range(1023));
        nbytes = $urandom_range(1, 4);
        for (k = 0; k < nbytes; k++) begin
          b.pos  = start + fsr_pkg::POS_W'(k);
          b.data = fsr_pkg::DATA_W'($urandom_range(255));
          b.last = (k == nbytes - 1);
          if ($urandom_range(99) < 5)
            b.last = ~b.last;
          batch.push_back(b);
        end
      end
    end
    if (nf > 1 && $urandom_range(1) == 1) begin
      for (j = batch.size() - 1; j > 0; j--) begin
        k = $urandom_range(j);
        t = batch[j];
        batch[j] = batch[k];
        batch[k] = t;
      end
    end
    foreach (batch[i]) offer_byte(batch[i], CHK_MODEL, '0);
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    fsr_pkg::res_t r;
    bit got;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_push && !in_full) begin
        got = predict_completion(cur_item, r);
        if (cur_chk == CHK_MODEL && got)
          pending_done.push_back(r);
        else if (cur_chk == CHK_DONE)
          pending_done.push_back(cur_res);
        n_accepted++;
        moved = 1'b1;
      end
      if (out_pop && !out_empty) begin
        moved = 1'b1;
        if (pending_done.size() == 0) begin
          fails++;
          $display("%0t: expected no completion, got slot %0d frame %0d bytes %0d",
                   $realtime, out_done_slot, out_done_frame, out_frame_bytes);
        end else begin
          r = pending_done.pop_front();
          if ({out_done_slot, out_done_frame, out_frame_bytes} !== r) begin
            fails++;
            $display("%0t: completion mismatch, expected slot %0d frame %0d bytes %0d,",
                     $realtime, r.done_slot, r.done_frame, r.frame_bytes);
            $display("%0t:   got slot %0d frame %0d bytes %0d",
                     $realtime, out_done_slot, out_done_frame, out_frame_bytes);
          end
        end
      end
      stall_cnt = moved ? 0 : stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    byte_item_t b;
    int goal;
    int i;
    rst_n      = 1'b0;
    in_push    = 1'b0;
    out_pop    = 1'b0;
    cur_item   = '0;
    cur_chk    = CHK_MODEL;
    cur_res    = '0;
    n_accepted = 0;
    fails      = 0;
    stall_cnt  = 0;
    hold_left  = 0;
    hold_req   = 1'b0;
    prev_base  = '0;
    send_idle  = 28;
    recv_idle  = 45;
    for (i = 0; i < fsr_pkg::SLOT_COUNT; i++) begin
      slot_owner[i]    = '0;
      slot_live[i]     = 1'b0;
      sections_left[i] = '0;
      byte_total[i]    = '0;
    end

    // extremes, empty count, late bytes, reclaim and interleaved slots
    dir_tab.push_back(stim_row(16'h0000,  0,   1,   0, 8'h00, 1, CHK_DONE, 0, 16'h0000, 1));
    dir_tab.push_back(stim_row(16'hFFFF, 63,   1, 1023, 8'hFF, 1, CHK_DONE, 3, 16'hFFFF, 1));
    dir_tab.push_back(stim_row(16'hFFFF, 63,   1, 1023, 8'h5A, 1, CHK_NONE, 0, 0, 0));
    dir_tab.push_back(stim_row(16'hFFFF,  0,  64,   0, 8'h11, 0, CHK_NONE, 0, 0, 0));
    dir_tab.push_back(stim_row(16'h0005,  0,   0,   7, 8'h22, 1, CHK_NONE, 0, 0, 0));
    dir_tab.push_back(stim_row(16'h0005,  1,   0,   8, 8'h23, 1, CHK_NONE, 0, 0, 0));
    dir_tab.push_back(stim_row(16'h0006,  0,   2,   0, 8'h33, 0, CHK_NONE, 0, 0, 0));
    dir_tab.push_back(stim_row(16'h0006,  0,   2,   1, 8'h34, 1, CHK_NONE, 0, 0, 0));
    dir_tab.push_back(stim_row(16'h0006,  1,   2,   0, 8'h35, 1, CHK_DONE, 2, 16'h0006, 3));
    dir_tab.push_back(stim_row(16'h000A,  3,   3, 100, 8'h44, 1, CHK_NONE, 0, 0, 0));
    dir_tab.push_back(stim_row(16'h0007,  0,   1,   0, 8'h45, 1, CHK_DONE, 3, 16'h0007, 1));
    dir_tab.push_back(stim_row(16'h000A,  2,   3,   5, 8'h46, 1, CHK_NONE, 0, 0, 0));
    dir_tab.push_back(stim_row(16'h000A,  1,   3,   0, 8'h47, 0, CHK_NONE, 0, 0, 0));
    dir_tab.push_back(stim_row(16'h000A,  0,   3,   0, 8'h48, 1, CHK_DONE, 2, 16'h000A, 4));
    dir_tab.push_back(stim_row(16'h0008,  0,   2,   0, 8'h49, 1, CHK_NONE, 0, 0, 0));
    dir_tab.push_back(stim_row(16'h000C,  5,   1,   9, 8'h4A, 1, CHK_DONE, 0, 16'h000C, 1));
    dir_tab.push_back(stim_row(16'h0008,  1,   2,   0, 8'h4B, 1, CHK_NONE, 0, 0, 0));
    dir_tab.push_back(stim_row(16'h8000, 42, 127, 682, 8'hAA, 1, CHK_MODEL, 0, 0, 0));
    dir_tab.push_back(stim_row(16'h7FFF, 21,  64, 341, 8'h55, 1, CHK_MODEL, 0, 0, 0));
    dir_tab.push_back(stim_row(16'h0001, 63,   1, 1023, 8'h80, 0, CHK_MODEL, 0, 0, 0));
    dir_tab.push_back(stim_row(16'h0001, 63,   1, 1022, 8'h81, 1, CHK_MODEL, 0, 0, 0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[n]) offer_byte(dir_tab[n].it, dir_tab[n].chk, dir_tab[n].res);

    goal = n_accepted + 520;
    while (n_accepted < goal) send_batch();

    send_idle = 45;
    recv_idle = 28;
    goal = n_accepted + 480;
    while (n_accepted < goal) send_batch();

    // receiver held off while single-section frames keep arriving
    send_idle = 0;
    recv_idle = 0;
    hold_req  = 1'b1;
    for (i = 0; i < 24; i++) begin
      b.frame = 16'h4000 + fsr_pkg::FRAME_W'(i);
      b.sec   = fsr_pkg::SEC_W'($urandom_range(63));
      b.cnt   = 1;
      b.pos   = fsr_pkg::POS_W'($urandom_range(1023));
      b.data  = fsr_pkg::DATA_W'($urandom_range(255));
      b.last  = 1'b1;
      offer_byte(b, CHK_MODEL, '0);
    end
    goal = n_accepted + 400;
    while (n_accepted < goal) send_batch();

    in_push <= 1'b0;
    while (pending_done.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fails == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
